### src/ims_pkg.sv
// shared types, command codes and phase tables of the i2c master bit sequencer
package ims_pkg;

	localparam int BYTE_BITS = 8;
	localparam int OP_W      = 3;
	localparam int PHASE_W   = 5;
	localparam int WAIT_W    = 8;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// command codes
	localparam logic [OP_W-1:0] OP_NONE     = 3'd0;
	localparam logic [OP_W-1:0] OP_START    = 3'd1;
	localparam logic [OP_W-1:0] OP_STOP     = 3'd2;
	localparam logic [OP_W-1:0] OP_WRITE    = 3'd3;
	localparam logic [OP_W-1:0] OP_READ     = 3'd4;
	localparam logic [OP_W-1:0] OP_READ_ACK = 3'd5;

	// register indexes
	localparam logic REG_LONG_WAIT  = 1'b0;
	localparam logic REG_SHORT_WAIT = 1'b1;

	localparam logic [WAIT_W-1:0] LONG_WAIT_RST  = 8'd2;
	localparam logic [WAIT_W-1:0] SHORT_WAIT_RST = 8'd1;

	// phase numbers past the data bits
	localparam logic [PHASE_W-1:0] PH_AFTER_BITS = PHASE_W'(2 * BYTE_BITS);
	localparam logic [PHASE_W-1:0] PH_ACK_SLOT   = PHASE_W'(2 * BYTE_BITS + 1);

	// one classified tick
	typedef struct packed {
		logic [OP_W-1:0]      cmd;
		logic [BYTE_BITS-1:0] tx_byte;
		logic                 ack_level;
		logic                 sda_in;
	} item_t;

	// number of phases for each command
	function automatic logic [PHASE_W-1:0] phase_total(input logic [OP_W-1:0] cmd);
		logic [PHASE_W-1:0] n;
		unique case (cmd)
			OP_START:    n = PHASE_W'(4);
			OP_STOP:     n = PHASE_W'(4);
			OP_WRITE:    n = PHASE_W'(2 * BYTE_BITS + 3);
			OP_READ:     n = PHASE_W'(2 * BYTE_BITS);
			OP_READ_ACK: n = PHASE_W'(2 * BYTE_BITS + 2);
			default:     n = '0;
		endcase
		return n;
	endfunction

	// a wait register of zero counts as one tick
	function automatic logic [WAIT_W-1:0] ticks_minus_one(input logic [WAIT_W-1:0] r);
		return (r == '0) ? '0 : r - WAIT_W'(1);
	endfunction

endpackage

### src/ims_cmd_if.sv
// command channel: one tick with its command and sampled sda level
interface ims_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [ims_pkg::OP_W-1:0]      operation;
	logic [ims_pkg::BYTE_BITS-1:0] tx_byte;
	logic                          ack_level;
	logic                          sda_in;

	modport source (output valid, operation, tx_byte, ack_level, sda_in, input ready);
	modport sink (input valid, operation, tx_byte, ack_level, sda_in, output ready);
endinterface

### src/ims_res_if.sv
// result channel: line drives and status of one tick
interface ims_res_if;
	logic                          valid;
	logic                          ready;
	logic                          scl_pull_low;
	logic                          sda_pull_low;
	logic                          busy_res;
	logic                          done_res;
	logic [ims_pkg::BYTE_BITS-1:0] rx_byte;
	logic                          ack_seen;

	modport source (output valid, scl_pull_low, sda_pull_low, busy_res, done_res, rx_byte,
		ack_seen, input ready);
	modport sink (input valid, scl_pull_low, sda_pull_low, busy_res, done_res, rx_byte,
		ack_seen, output ready);
endinterface

### src/ims_front.sv
// front stage: accepts ticks and classifies the command code
module ims_front (
	input  logic             clk,
	input  logic             arst_n,
	ims_cmd_if.sink          cmd,
	output logic             item_valid,
	output ims_pkg::item_t   item,
	input  logic             item_ready
);

	logic           valid_s1;
	ims_pkg::item_t item_s1;
	ims_pkg::item_t classified;
	logic           take;

	// unknown codes become no command
	always_comb begin
		classified.tx_byte   = cmd.tx_byte;
		classified.ack_level = cmd.ack_level;
		classified.sda_in    = cmd.sda_in;
		unique case (cmd.operation)
			ims_pkg::OP_START, ims_pkg::OP_STOP, ims_pkg::OP_WRITE,
			ims_pkg::OP_READ, ims_pkg::OP_READ_ACK: classified.cmd = cmd.operation;
			default: classified.cmd = ims_pkg::OP_NONE;
		endcase
	end

	assign cmd.ready = !valid_s1 || item_ready;
	assign take      = cmd.valid && cmd.ready;

	// stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= classified;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

### src/ims_queue.sv
// short queue between front and back
module ims_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  ims_pkg::item_t push_item,
	output logic           pop_valid,
	input  logic           pop_ready,
	output ims_pkg::item_t pop_item
);

	ims_pkg::item_t                entry_q [ims_pkg::QUEUE_DEPTH];
	logic [ims_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [ims_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [ims_pkg::QCNT_W-1:0]    count_q;
	logic                          push;
	logic                          pop;

	assign push_ready = (count_q != ims_pkg::QCNT_W'(ims_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + ims_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + ims_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + ims_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - ims_pkg::QCNT_W'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

### src/ims_back.sv
// back stage: steps the bus phase sequencer once per tick and registers the result
module ims_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  ims_pkg::item_t                 item,
	input  logic [ims_pkg::WAIT_W-1:0]     long_wait,
	input  logic [ims_pkg::WAIT_W-1:0]     short_wait,
	ims_res_if.source                      res
);

	// sequencer state
	logic [ims_pkg::OP_W-1:0]      cmd_q;
	logic [ims_pkg::PHASE_W-1:0]   phase_q;
	logic [ims_pkg::WAIT_W-1:0]    wait_q;
	logic [ims_pkg::BYTE_BITS-1:0] shift_q;
	logic                          ack_q;
	logic                          scl_q;
	logic                          sda_q;
	logic                          rack_q;
	logic [ims_pkg::BYTE_BITS-1:0] rx_q;

	// next state
	logic [ims_pkg::OP_W-1:0]      n_cmd;
	logic [ims_pkg::PHASE_W-1:0]   n_phase;
	logic [ims_pkg::WAIT_W-1:0]    n_wait;
	logic [ims_pkg::BYTE_BITS-1:0] n_shift;
	logic                          n_ack;
	logic                          n_scl;
	logic                          n_sda;
	logic                          n_rack;
	logic [ims_pkg::BYTE_BITS-1:0] n_rx;
	logic                          n_done;
	logic                          enter;
	logic [ims_pkg::PHASE_W-1:0]   ep;
	logic [ims_pkg::PHASE_W-1:0]   phase_inc;

	// output register
	logic                          out_valid_q;
	logic                          done_q;
	logic                          step;

	assign item_ready = !out_valid_q || res.ready;
	assign step       = item_valid && item_ready;
	assign phase_inc  = phase_q + ims_pkg::PHASE_W'(1);

	// one tick of the sequencer
	always_comb begin
		n_cmd   = cmd_q;
		n_phase = phase_q;
		n_wait  = wait_q;
		n_shift = shift_q;
		n_ack   = ack_q;
		n_scl   = scl_q;
		n_sda   = sda_q;
		n_rack  = rack_q;
		n_rx    = rx_q;
		n_done  = 1'b0;
		enter   = 1'b0;
		ep      = '0;

		if (cmd_q == ims_pkg::OP_NONE) begin
			if (item.cmd != ims_pkg::OP_NONE) begin
				n_cmd   = item.cmd;
				n_shift = item.tx_byte;
				n_ack   = item.ack_level;
				n_phase = '0;
				enter   = 1'b1;
				ep      = '0;
			end
		end else if (wait_q != '0) begin
			n_wait = wait_q - ims_pkg::WAIT_W'(1);
		end else if (phase_inc < ims_pkg::phase_total(cmd_q)) begin
			n_phase = phase_inc;
			enter   = 1'b1;
			ep      = phase_inc;
		end else begin
			// command complete
			if (cmd_q == ims_pkg::OP_READ || cmd_q == ims_pkg::OP_READ_ACK) begin
				n_scl = 1'b1;
				n_rx  = shift_q;
				if (cmd_q == ims_pkg::OP_READ_ACK) begin
					n_sda = 1'b0;
				end
			end
			n_cmd   = ims_pkg::OP_NONE;
			n_phase = '0;
			n_wait  = '0;
			n_done  = 1'b1;
		end

		// drives set on the first tick of a phase
		if (enter) begin
			n_wait = ims_pkg::ticks_minus_one(long_wait);
			if (n_cmd == ims_pkg::OP_START) begin
				if (ep == ims_pkg::PHASE_W'(0)) begin
					n_scl = 1'b0;
				end else if (ep == ims_pkg::PHASE_W'(1)) begin
					n_sda = 1'b0;
				end else if (ep == ims_pkg::PHASE_W'(2)) begin
					n_sda = 1'b1;
				end else begin
					n_scl = 1'b1;
				end
			end else if (n_cmd == ims_pkg::OP_STOP) begin
				n_wait = ims_pkg::ticks_minus_one(short_wait);
				if (ep == ims_pkg::PHASE_W'(0)) begin
					n_sda = 1'b1;
				end else if (ep == ims_pkg::PHASE_W'(1)) begin
					n_scl = 1'b1;
				end else if (ep == ims_pkg::PHASE_W'(2)) begin
					n_scl = 1'b0;
				end else begin
					n_sda = 1'b0;
				end
			end else if (ep < ims_pkg::PH_AFTER_BITS) begin
				// data bit phases
				if (!ep[0]) begin
					n_scl = 1'b1;
					if (n_cmd == ims_pkg::OP_WRITE) begin
						n_sda = !n_shift[~ep[3:1]];
					end else begin
						n_sda = 1'b0;
					end
				end else begin
					n_scl = 1'b0;
					if (n_cmd != ims_pkg::OP_WRITE) begin
						n_shift = {n_shift[ims_pkg::BYTE_BITS-2:0], item.sda_in};
					end
				end
			end else if (n_cmd == ims_pkg::OP_WRITE) begin
				// ack slot after a write
				if (ep == ims_pkg::PH_AFTER_BITS) begin
					n_scl = 1'b1;
					n_sda = 1'b0;
				end else if (ep == ims_pkg::PH_ACK_SLOT) begin
					n_scl  = 1'b0;
					n_rack = item.sda_in;
				end else begin
					n_scl = 1'b1;
				end
			end else begin
				// ack bit sent after a read
				if (ep == ims_pkg::PH_AFTER_BITS) begin
					n_scl = 1'b1;
					n_sda = !n_ack;
				end else begin
					n_scl = 1'b0;
				end
			end
		end
	end

	// state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q       <= ims_pkg::OP_NONE;
			phase_q     <= '0;
			wait_q      <= '0;
			shift_q     <= '0;
			ack_q       <= 1'b0;
			scl_q       <= 1'b0;
			sda_q       <= 1'b0;
			rack_q      <= 1'b0;
			rx_q        <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				cmd_q   <= n_cmd;
				phase_q <= n_phase;
				wait_q  <= n_wait;
				shift_q <= n_shift;
				ack_q   <= n_ack;
				scl_q   <= n_scl;
				sda_q   <= n_sda;
				rack_q  <= n_rack;
				rx_q    <= n_rx;
				done_q  <= n_done;
			end
			if (item_ready) begin
				out_valid_q <= item_valid;
			end
		end
	end

	// result beat
	assign res.valid        = out_valid_q;
	assign res.scl_pull_low = scl_q;
	assign res.sda_pull_low = sda_q;
	assign res.busy_res     = (cmd_q != ims_pkg::OP_NONE);
	assign res.done_res     = done_q;
	assign res.rx_byte      = rx_q;
	assign res.ack_seen     = rack_q;

endmodule

### src/i2c_master_bit_sequencer.sv
// top level of the i2c master bit sequencer: config registers, front, queue and back
//
//   channel | dir | beat
//   cmd     | in  | one bus tick: operation, tx_byte, ack_level, sda_in
//   res     | out | one result per tick: scl/sda drives, busy, done, rx_byte, ack_seen
//   apb     | in  | long_wait at 0x0, short_wait at 0x4
//
// one tick per clock cycle sustained while res takes each result; a tick's result is
// registered in the front register, a queue entry and the result register in turn
// the phase sequencer in the back steps once per tick and so sets the rate
// reset clears the sequencer to idle with both lines released and the queue empty
// a stall on res backs up into the four-entry queue before cmd.ready drops
module i2c_master_bit_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	ims_cmd_if.sink     cmd,
	ims_res_if.source   res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [ims_pkg::WAIT_W-1:0] long_wait_q;
	logic [ims_pkg::WAIT_W-1:0] short_wait_q;
	logic                       cfg_write;
	logic                       reg_sel;

	logic           f_valid;
	logic           f_ready;
	ims_pkg::item_t f_item;
	logic           b_valid;
	logic           b_ready;
	ims_pkg::item_t b_item;

	// configuration registers
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign reg_sel   = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_wait_q  <= ims_pkg::LONG_WAIT_RST;
			short_wait_q <= ims_pkg::SHORT_WAIT_RST;
		end else if (cfg_write) begin
			if (reg_sel == ims_pkg::REG_LONG_WAIT) begin
				long_wait_q <= pwdata[ims_pkg::WAIT_W-1:0];
			end else begin
				short_wait_q <= pwdata[ims_pkg::WAIT_W-1:0];
			end
		end
	end

	// register read
	always_comb begin
		if (reg_sel == ims_pkg::REG_LONG_WAIT) begin
			prdata = {{(32 - ims_pkg::WAIT_W){1'b0}}, long_wait_q};
		end else begin
			prdata = {{(32 - ims_pkg::WAIT_W){1'b0}}, short_wait_q};
		end
	end

	ims_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.item_valid (f_valid),
		.item       (f_item),
		.item_ready (f_ready)
	);

	ims_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_item  (f_item),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_item   (b_item)
	);

	ims_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (b_valid),
		.item_ready (b_ready),
		.item       (b_item),
		.long_wait  (long_wait_q),
		.short_wait (short_wait_q),
		.res        (res)
	);

endmodule
